>>> design/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared types and fixed constants of the frame rate meter and limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package frm_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned IVL_W    = 16;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned PERIOD_W = 24;
  localparam int unsigned DELAY_W  = 16;

  localparam logic [SUM_W-1:0]    FPS_SCALE      = 24'd256000;
  localparam logic [SUM_W-1:0]    FPS_DEFAULT_Q8 = 24'd15360;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 24'd4267;

  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } frm_div_stat_t;

endpackage

`default_nettype wire

>>> design/frm_ram.sv
// ----------------------------------------------------------------------------
// frm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 10,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/frm_div.sv
// ----------------------------------------------------------------------------
// frm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frm_div #(
  parameter int unsigned W = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [W-1:0]          dividend,
  input  wire logic [W-1:0]          divisor,
  output frm_pkg::frm_div_stat_t     stat,
  output logic      [W-1:0]          quotient
);

  import frm_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_r <= trial[W-1:0];
      end else begin
        rem_r <= shifted[W-1:0];
      end
      quo_r <= {quo_r[W-2:0], ~trial[W]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

>>> design/frame_rate_meter_limiter.sv
// A frame-begin transaction is taken in ST_IDLE and gives no result.
// A frame-end transaction passes ST_UPDATE and ST_SCALE, then the one-bit-per-cycle divider in
// ST_DIVIDE, and its result is registered for ST_OUT; a zero sum goes from ST_SCALE straight to ST_OUT.
// One transaction at a time: a new one is taken only in ST_IDLE, after the last result is taken.
// Reset (rst_n low, synchronous): meter history cleared, period register back to 4267.
// The interval ring is not cleared; an entry read before it is written is not used.
// ----------------------------------------------------------------------------
// frame_rate_meter_limiter
// Moving-average frame rate meter with a frame period limiter.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_rate_meter_limiter #(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_target_period_q8,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_frame_time_ms,
  output logic      [23:0] out_fps_q8,
  output logic      [15:0] out_delay_ms
);

  import frm_pkg::*;

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCALE,
    ST_DIVIDE,
    ST_OUT
  } state_t;

  state_t              state_r;
  logic [PERIOD_W-1:0] target_r;
  logic [TIME_W-1:0]   frame_start_r;
  logic [TIME_W-1:0]   last_end_r;
  logic                have_last_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   slot_nxt;
  logic [CNT_W-1:0]    fill_r;
  logic [IVL_W-1:0]    interval_r;
  logic [DELAY_W-1:0]  delay_r;
  logic [SUM_W-1:0]    fps_r;
  logic                out_valid_r;

  logic                in_acc;
  logic                full;
  logic [TIME_W-1:0]   since_end;
  logic [IVL_W-1:0]    interval_nxt;
  logic [TIME_W-1:0]   ticks;
  logic [PERIOD_W:0]   period_diff;
  logic [DELAY_W-1:0]  delay_nxt;
  logic [IVL_W-1:0]    oldest;
  logic                div_start;
  logic [SUM_W-1:0]    div_num;
  logic [SUM_W-1:0]    div_quo;
  frm_div_stat_t       div_stat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign full      = (fill_r == CNT_W'(WINDOW));

  assign since_end    = in_now_ms - last_end_r;
  assign interval_nxt = !have_last_r ? '0 :
                        (|since_end[TIME_W-1:IVL_W]) ? '1 : since_end[IVL_W-1:0];

  assign ticks       = in_now_ms - frame_start_r;
  assign period_diff = {1'b0, target_r} - {1'b0, ticks[15:0], 8'd0};
  assign delay_nxt   = ((|ticks[TIME_W-1:16]) || period_diff[PERIOD_W]) ? '0 :
                       period_diff[PERIOD_W-1:8];

  assign sum_nxt  = sum_r - (full ? SUM_W'(oldest) : '0) + SUM_W'(interval_r);
  assign slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;

  assign div_start = (state_r == ST_SCALE) && (sum_r != '0);
  assign div_num   = SUM_W'(FPS_SCALE * SUM_W'(fill_r));

  frm_ram #(
    .WIDTH (IVL_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .we      (state_r == ST_UPDATE),
    .waddr   (slot_r),
    .wdata   (interval_r),
    .re      (in_acc),
    .raddr   (slot_r),
    .rdata_r (oldest)
  );

  frm_div #(
    .W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (sum_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      target_r      <= PERIOD_RESET;
      frame_start_r <= '0;
      last_end_r    <= '0;
      have_last_r   <= 1'b0;
      sum_r         <= '0;
      slot_r        <= '0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_target_period_q8;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_kind == KIND_BEGIN) begin
              frame_start_r <= in_now_ms;
            end else begin
              interval_r  <= interval_nxt;
              delay_r     <= delay_nxt;
              last_end_r  <= in_now_ms;
              have_last_r <= 1'b1;
              state_r     <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          sum_r  <= sum_nxt;
          slot_r <= slot_nxt;
          if (!full) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          if (sum_r == '0) begin
            fps_r       <= FPS_DEFAULT_Q8;
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end else begin
            state_r <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_stat.done) begin
            fps_r       <= div_quo;
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_time_ms = interval_r;
  assign out_fps_q8        = fps_r;
  assign out_delay_ms      = delay_r;

  a_out_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready)
    else $error("input taken while a result is pending");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIVIDE))
    else $error("divider finished outside divide state");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_end_updates: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_kind == KIND_END)) |=> (state_r == ST_UPDATE))
    else $error("frame end transaction did not start an update");

endmodule

`default_nettype wire
